/* design/clws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clws_pkg
// shared types and constants of the character lcd write sequencer
// ----------------------------------------------------------------------------
package clws_pkg;

  typedef enum logic [2:0] {
    CMD_INIT  = 3'd0,
    CMD_INSTR = 3'd1,
    CMD_DATA  = 3'd2,
    CMD_MOVE  = 3'd3,
    CMD_NUM   = 3'd4
  } cmd_t;

  localparam int unsigned NUM_W = 31;

  // init tables: byte and pause before, indexed by init step
  function automatic logic [7:0] init8_byte(input logic [3:0] i);
    case (i)
      4'd0: init8_byte = 8'h38;
      4'd1: init8_byte = 8'h0C;
      4'd2: init8_byte = 8'h01;
      default: init8_byte = 8'h06;
    endcase
  endfunction

  function automatic logic [5:0] init8_wait(input logic [3:0] i);
    case (i)
      4'd0: init8_wait = 6'd40;
      4'd1: init8_wait = 6'd1;
      4'd2: init8_wait = 6'd1;
      default: init8_wait = 6'd3;
    endcase
  endfunction

  function automatic logic [7:0] init4_byte(input logic [3:0] i);
    case (i)
      4'd0: init4_byte = 8'h02;
      4'd1: init4_byte = 8'h20;
      4'd2: init4_byte = 8'h20;
      4'd3: init4_byte = 8'h80;
      4'd4: init4_byte = 8'h00;
      4'd5: init4_byte = 8'hC0;
      4'd6: init4_byte = 8'h00;
      4'd7: init4_byte = 8'h10;
      4'd8: init4_byte = 8'h00;
      default: init4_byte = 8'h60;
    endcase
  endfunction

  function automatic logic [5:0] init4_wait(input logic [3:0] i);
    case (i)
      4'd1: init4_wait = 6'd30;
      4'd4: init4_wait = 6'd1;
      4'd6: init4_wait = 6'd1;
      4'd8: init4_wait = 6'd3;
      default: init4_wait = 6'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* design/char_lcd_write_sequencer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer_top
// expands lcd requests into enable strobes, 8-bit or 4-bit bus
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tdata: cmd, byte_value, row, column, number
// m_axis   out  tvalid/tready, tlast   tdata: rs, bus_value, wait_before, wait_after
// cfg      in   cfg_valid/cfg_ready    cfg_data: bus_mode
//
// a request is taken only while idle; init gives one strobe per cycle while
// the output takes them, a number yields one digit per cycle through a shared
// divide-by-ten step, then each digit is a ram read and a strobe on an 8-bit
// bus, plus a lower-nibble strobe on a 4-bit bus.
// each strobe waits in the output register until taken; stalls hold the work.
// synchronous reset clears control state and bus_mode.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top
  import clws_pkg::*;
#(
  parameter int unsigned MAX_DIGITS      = 10,
  parameter int unsigned VISIBLE_COLUMNS = 16,
  parameter int unsigned LINE_LENGTH     = 40
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[2:0], byte_value[10:3], row[11], column[17:12], number[48:18]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // rs[0], bus_value[8:1], wait_before_ms[14:9], wait_after_ms[20:15]
  output logic      [23:0] m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  localparam int unsigned DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_BYTE, S_DIV, S_READ, S_DIGIT
  } state_t;

  state_t           state;
  logic             bus_mode;
  logic             init_done;
  logic [3:0]       step;
  logic             is_last_step;
  logic [NUM_W-1:0] work_value;
  logic [CW-1:0]    digit_count;
  logic             out_full;
  logic             out_load;
  logic             rs_r;
  logic [7:0]       bus_r;
  logic [5:0]       wb_r;
  logic [5:0]       wa_r;
  logic             last_r;
  logic             lo_pend;
  logic [3:0]       lo_nib;
  logic             lo_last;
  logic             lo_rs;
  logic             byte_rs;
  logic [7:0]       byte_val;
  logic             byte_last;
  logic             strobe_rs;
  logic [7:0]       strobe_val;

  logic [2:0]       in_cmd;
  logic [7:0]       in_byte;
  logic             in_row;
  logic [5:0]       in_col;
  logic [NUM_W-1:0] in_num;

  logic [NUM_W-1:0] quot;
  logic [3:0]       rem;
  logic             ram_we;
  logic [DW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_raddr;
  logic [3:0]       ram_rdata;
  logic [7:0]       addr;
  logic             slot_free;

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_byte = s_axis_tdata[10:3];
  assign in_row  = s_axis_tdata[11];
  assign in_col  = s_axis_tdata[17:12];
  assign in_num  = s_axis_tdata[48:18];

  assign s_axis_tready = (state == S_IDLE) && !out_full;
  assign cfg_ready     = (state == S_IDLE) && !out_full;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {3'b000, wa_r, wb_r, bus_r, rs_r};
  assign m_axis_tlast  = last_r;
  assign slot_free     = !out_full || m_axis_tready;
  assign out_load      = lo_pend ? slot_free
                                 : (slot_free && (state inside {S_INIT, S_BYTE, S_DIGIT}));

  // shared divide-by-ten unit
  assign quot = NUM_W'((64'(work_value) * 64'd3435973837) >> 35);
  assign rem  = 4'(work_value - NUM_W'(quot * NUM_W'(10)));

  assign ram_we    = (state == S_DIV);
  assign ram_waddr = DW'(digit_count);
  assign ram_raddr = (state == S_READ) ? DW'(digit_count - CW'(1)) : DW'(digit_count);

  clws_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    addr = 8'd0;
    if (32'(in_col) < LINE_LENGTH)
      addr = 8'(32'(in_col) % VISIBLE_COLUMNS) + (in_row ? 8'h40 : 8'h00);
  end

  always_comb begin
    byte_last  = (state == S_BYTE) || (digit_count == CW'(0));
    strobe_rs  = (state == S_DIGIT) || byte_rs;
    strobe_val = (state == S_DIGIT) ? (8'h30 + {4'h0, ram_rdata}) : byte_val;
  end

  assign is_last_step = bus_mode ? (step == 4'd9) : (step == 4'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bus_mode    <= 1'b0;
      init_done   <= 1'b0;
      out_full    <= 1'b0;
      lo_pend     <= 1'b0;
      step        <= '0;
      digit_count <= '0;
      work_value  <= '0;
    end else begin
      if (out_load) out_full <= 1'b1;
      else if (m_axis_tready) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) bus_mode <= cfg_data;
      if (lo_pend) begin
        if (slot_free) begin
          rs_r     <= lo_rs;
          bus_r    <= {lo_nib, 4'h0};
          wb_r     <= 6'd0;
          wa_r     <= 6'd2;
          last_r   <= lo_last;
          lo_pend  <= 1'b0;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (s_axis_tvalid && s_axis_tready) begin
              step <= '0;
              case (in_cmd)
                CMD_INIT: begin
                  init_done <= 1'b0;
                  state     <= S_INIT;
                end
                CMD_INSTR: begin
                  byte_rs <= 1'b0; byte_val <= in_byte; state <= S_BYTE;
                end
                CMD_DATA: begin
                  byte_rs <= 1'b1; byte_val <= in_byte; state <= S_BYTE;
                end
                CMD_MOVE: begin
                  byte_rs <= 1'b0; byte_val <= addr + 8'd128; state <= S_BYTE;
                end
                CMD_NUM: begin
                  work_value  <= in_num;
                  digit_count <= '0;
                  state       <= S_DIV;
                end
                default: state <= S_IDLE;
              endcase
            end
          end
          S_INIT: begin
            if (slot_free) begin
              rs_r     <= 1'b0;
              last_r   <= is_last_step;
              if (bus_mode) begin
                bus_r <= init4_byte(step) & 8'hF0;
                wb_r  <= init4_wait(step);
              end else begin
                bus_r <= init8_byte(step);
                wb_r  <= init8_wait(step);
              end
              wa_r <= 6'd2;
              step <= step + 4'd1;
              if (is_last_step) begin
                init_done <= 1'b1;
                state     <= S_IDLE;
              end
            end
          end
          S_BYTE, S_DIGIT: begin
            if (slot_free) begin
              rs_r     <= strobe_rs;
              wb_r     <= 6'd0;
              if (bus_mode && (strobe_rs || init_done)) begin
                bus_r   <= strobe_val & 8'hF0;
                wa_r    <= 6'd0;
                last_r  <= 1'b0;
                lo_pend <= 1'b1;
                lo_nib  <= strobe_val[3:0];
                lo_rs   <= strobe_rs;
                lo_last <= byte_last;
              end else begin
                bus_r  <= bus_mode ? (strobe_val & 8'hF0) : strobe_val;
                wa_r   <= 6'd2;
                last_r <= byte_last;
              end
              state <= byte_last ? S_IDLE : S_READ;
            end
          end
          S_DIV: begin
            work_value  <= quot;
            digit_count <= digit_count + CW'(1);
            if (quot == '0 || (32'(digit_count) + 1 >= MAX_DIGITS)) state <= S_READ;
          end
          S_READ: begin
            digit_count <= digit_count - CW'(1);
            state       <= S_DIGIT;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !out_full)
    else $error("request taken while a strobe is pending");
  assert property (@(posedge clk) disable iff (rst)
    lo_pend |-> (state == S_IDLE || state == S_READ))
    else $error("lower nibble pending during unexpected state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (32'(digit_count) < MAX_DIGITS))
    else $error("digit store overflow");
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (state == S_IDLE))
    else $error("configuration written while busy");

endmodule
`default_nettype wire

/* design/clws_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clws_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module clws_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the character lcd write sequencer: requests are
// driven on the input stream, each accepted request is expanded into its
// expected strobes by a behavioural predictor, and every strobe leaving the
// block is compared field by field in order. runs in both bus modes with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import clws_pkg::*;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic [5:0] pre_ms;
    logic [5:0] post_ms;
    logic       last;
  } strobe_t;

  class strobe_board;
    strobe_t pending[$];
    bit      four_bit;
    bit      ready_done;
    int      errors;

    function void push_strobe(bit rs, logic [7:0] b, logic [5:0] pre, logic [5:0] post);
      strobe_t s;
      s.rs = rs; s.bus = b; s.pre_ms = pre; s.post_ms = post; s.last = 1'b0;
      pending.push_back(s);
    endfunction

    function void push_byte(bit rs, logic [7:0] b, logic [5:0] pre);
      if (!four_bit) push_strobe(rs, b, pre, 6'd2);
      else if (rs || ready_done) begin
        push_strobe(rs, {b[7:4], 4'h0}, pre, 6'd0);
        push_strobe(rs, {b[3:0], 4'h0}, 6'd0, 6'd2);
      end else push_strobe(rs, {b[7:4], 4'h0}, pre, 6'd2);
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] b, logic row, logic [5:0] col,
                               logic [30:0] num);
      int before_n;
      int cnt;
      logic [7:0] addr;
      logic [3:0] digits[10];
      logic [30:0] w;
      before_n = pending.size();
      case (cmd)
        CMD_INIT: begin
          ready_done = 0;
          if (!four_bit) begin
            push_byte(0, 8'h38, 6'd40); push_byte(0, 8'h0C, 6'd1);
            push_byte(0, 8'h01, 6'd1);  push_byte(0, 8'h06, 6'd3);
          end else begin
            push_byte(0, 8'h02, 6'd0); push_byte(0, 8'h20, 6'd30);
            push_byte(0, 8'h20, 6'd0); push_byte(0, 8'h80, 6'd0);
            push_byte(0, 8'h00, 6'd1); push_byte(0, 8'hC0, 6'd0);
            push_byte(0, 8'h00, 6'd1); push_byte(0, 8'h10, 6'd0);
            push_byte(0, 8'h00, 6'd3); push_byte(0, 8'h60, 6'd0);
          end
          ready_done = 1;
        end
        CMD_INSTR: push_byte(0, b, 6'd0);
        CMD_DATA: push_byte(1, b, 6'd0);
        CMD_MOVE: begin
          addr = 8'h00;
          if (col < 40) addr = {4'h0, col[3:0]} + (row ? 8'h40 : 8'h00);
          push_byte(0, addr + 8'h80, 6'd0);
        end
        CMD_NUM: begin
          w = num; cnt = 0;
          do begin
            digits[cnt] = 4'(w % 31'd10); w = 31'(w / 31'd10); cnt++;
          end while (w != 0 && cnt < 10);
          while (cnt > 0) begin
            cnt--;
            push_byte(1, 8'h30 + {4'h0, digits[cnt]}, 6'd0);
          end
        end
        default: ;
      endcase
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_strobe(strobe_t got);
      strobe_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected strobe %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: strobe mismatch expected rs=%b bus=%h pre=%0d post=%0d last=%b",
                 $time, want.rs, want.bus, want.pre_ms, want.post_ms, want.last);
        $display("%0t:                 actual   rs=%b bus=%h pre=%0d post=%0d last=%b",
                 $time, got.rs, got.bus, got.pre_ms, got.post_ms, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_data = 0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 0;
  strobe_board board;

  char_lcd_write_sequencer_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // output side: random ready, checks on each transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_strobe({m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[14:9],
                            m_axis_tdata[20:15], m_axis_tlast});
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high after a transaction until the next request or an idle cycle
  task automatic send_request(logic [2:0] cmd, logic [7:0] b, logic row, logic [5:0] col,
                              logic [30:0] num);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tdata  <= {7'd0, num, col, row, b, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(cmd, b, row, col, num);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_bus_mode(bit mode);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.four_bit = mode;
  endtask

  task automatic random_request;
    logic [2:0]  cmd;
    logic [30:0] num;
    int k;
    k = $urandom_range(99);
    if (k < 5) cmd = CMD_INIT;
    else if (k < 25) cmd = CMD_INSTR;
    else if (k < 45) cmd = CMD_DATA;
    else if (k < 65) cmd = CMD_MOVE;
    else if (k < 95) cmd = CMD_NUM;
    else cmd = 3'($urandom_range(7, 5));
    case ($urandom_range(3))
      0: num = 31'($urandom_range(99));
      1: num = 31'($urandom);
      2: num = 31'($urandom_range(999999));
      default: num = ($urandom_range(1)) ? 31'h7FFFFFFF : 31'd0;
    endcase
    send_request(cmd, 8'($urandom), 1'($urandom), 6'($urandom), num);
  endtask

  task automatic directed_part;
    send_request(CMD_INSTR, 8'hA5, 0, 0, 0);
    send_request(CMD_DATA, 8'h00, 0, 0, 0);
    send_request(CMD_INIT, 8'h00, 0, 0, 0);
    send_request(CMD_INIT, 8'hFF, 1, 63, 31'h7FFFFFFF);
    send_request(CMD_INSTR, 8'hFF, 0, 0, 0);
    send_request(CMD_DATA, 8'hFF, 0, 0, 0);
    send_request(CMD_DATA, 8'h5A, 0, 0, 0);
    send_request(CMD_MOVE, 0, 0, 0, 0);
    send_request(CMD_MOVE, 0, 1, 15, 0);
    send_request(CMD_MOVE, 0, 1, 39, 0);
    send_request(CMD_MOVE, 0, 1, 40, 0);
    send_request(CMD_MOVE, 0, 0, 63, 0);
    send_request(CMD_NUM, 0, 0, 0, 0);
    send_request(CMD_NUM, 0, 0, 0, 31'h7FFFFFFF);
    send_request(CMD_NUM, 0, 0, 0, 31'd1000000000);
    send_request(CMD_NUM, 0, 0, 0, 31'd9);
    send_request(3'd5, 8'h12, 0, 1, 5);
    send_request(3'd7, 8'hFF, 1, 63, 31'h7FFFFFFF);
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      set_bus_mode(!phase[0]);
      send_idle_pct = 0; recv_idle_pct = 0;
      if (phase < 2) begin
        // four-bit before init sends only the upper nibble of an instruction
        send_request(CMD_INSTR, 8'h3C, 0, 0, 0);
        send_request(CMD_DATA, 8'hC3, 0, 0, 0);
      end
      directed_part();
      drain();
      for (int i = 0; i < 60; i++) begin
        if (i == 20) begin send_idle_pct = 54; recv_idle_pct = 38; end
        if (i < 20) begin send_idle_pct = 38; recv_idle_pct = 54; end
        if (i == 40) begin send_idle_pct = 0; recv_idle_pct = 0; end
        if (i == 45) begin
          fork
            begin
              recv_hold = 1;
              repeat (300) @(posedge clk);
              recv_hold = 0;
            end
          join_none
        end
        if (i == 30) drain();
        random_request();
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
